// ----- rtl/p2pgs_pkg.sv -----
// ----------------------------------------------------------------------------
// p2pgs_pkg
// Shared types and constants of the peak-to-peak gain stepper.
// ----------------------------------------------------------------------------
package p2pgs_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int LIMIT_W   = 8;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 1'd1;

   localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 8'd89;
   localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 8'd44;

   typedef struct packed {
      logic [LIMIT_W-1:0] high_limit;
      logic [LIMIT_W-1:0] low_limit;
   } limits_type;

   typedef struct packed {
      logic       gain_changed;
      logic [1:0] gain_stage;
      logic       waiting;
   } result_type;

endpackage

// ----- rtl/p2pgs_csr.sv -----
// ----------------------------------------------------------------------------
// p2pgs_csr
// Limit registers, written through the plain write port.
// ----------------------------------------------------------------------------
module p2pgs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [p2pgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [p2pgs_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output p2pgs_pkg::limits_type               limits
);

   p2pgs_pkg::limits_type limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.high_limit <= p2pgs_pkg::HIGH_LIMIT_RST;
         limits_ff.low_limit  <= p2pgs_pkg::LOW_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            p2pgs_pkg::CSR_HIGH_LIMIT: limits_ff.high_limit <= csr_wdata;
            p2pgs_pkg::CSR_LOW_LIMIT:  limits_ff.low_limit  <= csr_wdata;
         endcase
      end
   end

   assign limits = limits_ff;

endmodule

// ----- rtl/p2pgs_core.sv -----
// ----------------------------------------------------------------------------
// p2pgs_core
// Window tracker and stage decision: each accepted beat updates the registered state.
// ----------------------------------------------------------------------------
module p2pgs_core #(
   parameter int WINDOW     = 256,
   parameter int NUM_STAGES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [p2pgs_pkg::SAMPLE_W-1:0]    sample,
   input  logic                              restart_window,
   input  p2pgs_pkg::limits_type             limits,
   output p2pgs_pkg::result_type             result
);

   localparam int CW      = p2pgs_pkg::CNT_W;
   localparam int SW      = p2pgs_pkg::SAMPLE_W;
   localparam int STAGE_W = (NUM_STAGES > 4) ? $clog2(NUM_STAGES) : 2;
   localparam logic [STAGE_W-1:0] STAGE_TOP  = STAGE_W'(NUM_STAGES - 1);
   localparam logic [CW-1:0]      WINDOW_LEN = CW'(WINDOW);

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_GATHER = 2'd1,
      PH_WAIT   = 2'd2
   } phase_type;

   phase_type           phase_ff, phase_in, phase_cur;
   logic [CW-1:0]       count_ff, count_in, count_inc;
   logic [SW-1:0]       max_ff, max_in, min_ff, min_in, amp;
   logic [STAGE_W-1:0]  stage_ff, stage_in;
   logic                wait_done_ff, wait_done_in;
   logic                changed;

   always_comb begin
      phase_cur    = restart_window ? PH_START : phase_ff;
      phase_in     = phase_cur;
      count_inc    = count_ff + 1'b1;
      count_in     = count_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      stage_in     = stage_ff;
      wait_done_in = wait_done_ff;
      changed      = 1'b0;
      amp          = '0;
      unique case (phase_cur)
         PH_GATHER: begin
            count_in = count_inc;
            if (sample > max_ff) begin
               max_in = sample;
            end else if (sample < min_ff) begin
               min_in = sample;
            end
            if (count_inc >= WINDOW_LEN) begin
               amp = max_in - min_in;
               if (amp <= limits.low_limit && stage_ff < STAGE_TOP) begin
                  stage_in = stage_ff + 1'b1;
                  phase_in = PH_START;
                  changed  = 1'b1;
               end else if (amp >= limits.high_limit && stage_ff != '0) begin
                  if (wait_done_ff) begin
                     stage_in = stage_ff - 1'b1;
                     phase_in = PH_START;
                     changed  = 1'b1;
                  end else begin
                     count_in = '0;
                     phase_in = PH_WAIT;
                  end
               end else begin
                  phase_in = PH_START;
               end
            end
         end
         PH_WAIT: begin
            count_in = count_inc;
            if (count_inc >= WINDOW_LEN) begin
               wait_done_in = 1'b1;
               max_in       = sample;
               min_in       = sample;
               count_in     = CW'(1);
               phase_in     = PH_GATHER;
            end
         end
         default: begin
            wait_done_in = 1'b0;
            count_in     = CW'(1);
            max_in       = sample;
            min_in       = sample;
            phase_in     = PH_GATHER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         count_ff     <= '0;
         max_ff       <= '0;
         min_ff       <= '0;
         stage_ff     <= STAGE_TOP;
         wait_done_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         stage_ff     <= stage_in;
         wait_done_ff <= wait_done_in;
      end
   end

   assign result.gain_changed = changed;
   assign result.gain_stage   = stage_in[1:0];
   assign result.waiting      = (phase_in == PH_WAIT);

endmodule

// ----- rtl/peak_to_peak_gain_stepper.sv -----
// ----------------------------------------------------------------------------
// peak_to_peak_gain_stepper
// Peak-to-peak automatic gain control with settle window before a decrease.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while req_stall is low and returns exactly
// one result beat for it, in order. A sample is captured in an input register,
// the window tracker updates its state from it, and the result lands in an
// output register. The tracker takes a new sample as soon as the last one is
// done, so the rate is one sample per cycle, sustained while the result side
// is not stalled. A stall on the result side holds the output register and
// reaches req_stall only once the input register is also full. The user must
// write limits through the csr_ port only while no beat is in flight; the
// block does not enforce this. Limits reset to 89 (high) and 44 (low). The
// stage starts at NUM_STAGES - 1, and rsp_gain_stage shows its low two bits.
// ----------------------------------------------------------------------------
module peak_to_peak_gain_stepper #(
   parameter int WINDOW     = 256,
   parameter int NUM_STAGES = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [p2pgs_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                               req_restart_window,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_gain_changed,
   output logic [1:0]                         rsp_gain_stage,
   output logic                               rsp_waiting,
   input  logic                               csr_write_en,
   input  logic [p2pgs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [p2pgs_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   logic                              in_valid_ff;
   logic [p2pgs_pkg::SAMPLE_W-1:0]    sample_ff;
   logic                              restart_ff;
   logic                              rsp_valid_ff;
   p2pgs_pkg::result_type             result_ff;
   p2pgs_pkg::result_type             result;
   p2pgs_pkg::limits_type             limits;
   logic                              out_free;
   logic                              step_en;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   p2pgs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .limits       (limits)
   );

   p2pgs_core #(
      .WINDOW     (WINDOW),
      .NUM_STAGES (NUM_STAGES)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .sample         (sample_ff),
      .restart_window (restart_ff),
      .limits         (limits),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sample_ff  <= req_sample;
         restart_ff <= req_restart_window;
      end
      if (step_en) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gain_changed = result_ff.gain_changed;
   assign rsp_gain_stage   = result_ff.gain_stage;
   assign rsp_waiting      = result_ff.waiting;

endmodule

// ----- rtl/p2pgs_checker.sv -----
// ----------------------------------------------------------------------------
// p2pgs_checker
// Port-level checks of the gain stepper, bound to the top level.
// ----------------------------------------------------------------------------
module p2pgs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_gain_changed,
   input logic [1:0] rsp_gain_stage,
   input logic       rsp_waiting
);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_gain_changed) && $stable(rsp_gain_stage)
         && $stable(rsp_waiting))
      else $error("stalled result beat changed");

   a_no_change_while_waiting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_waiting |-> !rsp_gain_changed)
      else $error("gain changed on a beat that enters the settle window");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present right after reset");

endmodule

bind peak_to_peak_gain_stepper p2pgs_checker u_p2pgs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_gain_changed (rsp_gain_changed),
   .rsp_gain_stage   (rsp_gain_stage),
   .rsp_waiting      (rsp_waiting)
);
